[rtl/core/alvi_pkg.sv]
package alvi_pkg;

   localparam int unsigned RegWidth   = 31;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned DiffWidth  = 33;
   localparam int unsigned LimWidth   = 47;
   localparam int unsigned SumWidth   = 67;
   localparam int unsigned RootWidth  = 34;
   localparam int unsigned ScaleBits  = 28;
   localparam int unsigned FactWidth  = 29;
   localparam int unsigned FracBits   = 16;
   localparam int unsigned NumCells   = 34;
   localparam int unsigned QuoBits    = 29;
   localparam int unsigned NumRegs    = 2;
   localparam int unsigned IdxWidth   = 1;

   localparam logic [IdxWidth-1:0] RegTimeStep  = 1'd0;
   localparam logic [IdxWidth-1:0] RegRestSpeed = 1'd1;

   localparam logic [RegWidth-1:0] TimeStepReset  = 31'd1092;
   localparam logic [RegWidth-1:0] RestSpeedReset = 31'd7;

   typedef struct packed {
      logic signed [WordWidth-1:0] vel_x;
      logic signed [WordWidth-1:0] vel_y;
      logic signed [WordWidth-1:0] vel_z;
      logic signed [WordWidth-1:0] want_x;
      logic signed [WordWidth-1:0] want_y;
      logic signed [WordWidth-1:0] want_z;
      logic signed [WordWidth-1:0] pos_x;
      logic signed [WordWidth-1:0] pos_y;
      logic signed [WordWidth-1:0] pos_z;
      logic [RegWidth-1:0]         max_accel;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] new_vel_x;
      logic signed [WordWidth-1:0] new_vel_y;
      logic signed [WordWidth-1:0] new_vel_z;
      logic signed [WordWidth-1:0] new_pos_x;
      logic signed [WordWidth-1:0] new_pos_y;
      logic signed [WordWidth-1:0] new_pos_z;
      logic                        was_limited;
      logic                        at_rest;
   } rsp_type;

   // Item travelling down the cell chain
   typedef struct packed {
      logic signed [WordWidth-1:0] vel_x;
      logic signed [WordWidth-1:0] vel_y;
      logic signed [WordWidth-1:0] vel_z;
      logic signed [WordWidth-1:0] pos_x;
      logic signed [WordWidth-1:0] pos_y;
      logic signed [WordWidth-1:0] pos_z;
      logic signed [DiffWidth-1:0] d_x;
      logic signed [DiffWidth-1:0] d_y;
      logic signed [DiffWidth-1:0] d_z;
      logic [SumWidth-1:0]         sum;   // S, then remainder of the root
      logic [RootWidth-1:0]        root;
      logic [LimWidth-1:0]         lim;
      logic                        limited;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic                 stall;
   } ctl_type;

   function automatic logic [WordWidth-1:0] sat32(input logic signed [WordWidth+1:0] v);
      logic [WordWidth-1:0] r;
      r = v[WordWidth-1:0];
      if (v > $signed({3'b000, {(WordWidth-1){1'b1}}}))
         r = {1'b0, {(WordWidth-1){1'b1}}};
      else if (v < -$signed({3'b001, {(WordWidth-1){1'b0}}}))
         r = {1'b1, {(WordWidth-1){1'b0}}};
      return r;
   endfunction

endpackage

[rtl/core/alvi_if.sv]
interface alvi_req_if;
   import alvi_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface alvi_rsp_if;
   import alvi_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/alvi_root_cell.sv]
// One restoring square-root step; the item moves one cell per cycle while the chain is not stalled.
module alvi_root_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  alvi_pkg::ctl_type    ctl,
   input  logic [5:0]           bit_pos,
   input  logic                 in_valid,
   input  alvi_pkg::item_type   in_item,
   output logic                 out_valid,
   output alvi_pkg::item_type   out_item
);
   import alvi_pkg::*;

   logic               valid_ff;
   item_type           item_ff, item_in;
   logic [SumWidth:0]  trial;
   logic [SumWidth:0]  rem;

   always_comb begin
      item_in = in_item;
      // trial = (2*root + 2^b) * 2^b
      trial = ({1'b0, {(SumWidth-RootWidth){1'b0}}, in_item.root} << (bit_pos + 6'd1))
            | ({{SumWidth{1'b0}}, 1'b1} << {bit_pos, 1'b0});
      rem = {1'b0, in_item.sum};
      if (trial <= rem) begin
         item_in.sum  = SumWidth'(rem - trial);
         item_in.root = in_item.root | (RootWidth'(1) << bit_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         valid_ff <= in_valid;
      end
      if (!ctl.stall) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[rtl/core/alvi_div_cell.sv]
// One restoring division step of the scale factor; partial remainder rides along.
module alvi_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  alvi_pkg::ctl_type             ctl,
   input  logic [5:0]                    bit_pos,
   input  logic                          in_valid,
   input  alvi_pkg::item_type            in_item,
   input  logic [alvi_pkg::RootWidth:0]  in_rem,
   input  logic [alvi_pkg::FactWidth-1:0] in_quo,
   output logic                          out_valid,
   output alvi_pkg::item_type            out_item,
   output logic [alvi_pkg::RootWidth:0]  out_rem,
   output logic [alvi_pkg::FactWidth-1:0] out_quo
);
   import alvi_pkg::*;

   logic                 valid_ff;
   item_type             item_ff;
   logic [RootWidth:0]   rem_ff, rem_in;
   logic [FactWidth-1:0] quo_ff, quo_in;
   logic [RootWidth+1:0] shifted;
   logic                 num_bit;

   always_comb begin
      // numerator is M * 2^28: only bit 28 (M's lowest bit) can be set here
      num_bit = (bit_pos == 6'(ScaleBits)) ? in_item.lim[0] : 1'b0;
      shifted = {in_rem, num_bit};
      rem_in  = in_rem[RootWidth:0] << 1 | {{RootWidth{1'b0}}, num_bit};
      quo_in  = in_quo << 1;
      if (shifted >= {2'b00, in_item.root}) begin
         rem_in = (RootWidth+1)'(shifted - {2'b00, in_item.root});
         quo_in = in_quo << 1 | FactWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         valid_ff <= in_valid;
      end
      if (!ctl.stall) begin
         item_ff <= in_item;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
endmodule

[rtl/core/accel_limited_velocity_integrator.sv]
// Throughput: one transfer per cycle while rsp is not stalled; the chain holds one item per cell.
// The depth is set by the 34 square-root cells and 29 division cells,
// one result bit per cell, plus three front and four back stages.
// Reset (synchronous, active high) empties the chain and restores the
// registers to time_step 1092 and rest_speed 7.
module accel_limited_velocity_integrator (
   input  logic                                  clock,
   input  logic                                  reset,
   alvi_req_if.sink                              req,
   alvi_rsp_if.source                            rsp,
   input  logic                                  csr_we,
   input  logic [alvi_pkg::IdxWidth-1:0]         csr_index,
   input  logic [alvi_pkg::RegWidth-1:0]         csr_wdata
);
   import alvi_pkg::*;

   localparam int unsigned QuoLead = LimWidth + ScaleBits - QuoBits;

   logic [RegWidth-1:0] time_step_ff, rest_speed_ff;
   ctl_type             ctl;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= TimeStepReset;
         rest_speed_ff <= RestSpeedReset;
      end else if (csr_we) begin
         case (csr_index)
            RegTimeStep:  time_step_ff  <= csr_wdata;
            RegRestSpeed: rest_speed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage A: differences and step-limit product
   logic     a_valid_ff;
   item_type a_item_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         a_valid_ff <= req.valid;
      end
      if (!ctl.stall) begin
         a_item_ff.vel_x <= req.data.vel_x;
         a_item_ff.vel_y <= req.data.vel_y;
         a_item_ff.vel_z <= req.data.vel_z;
         a_item_ff.pos_x <= req.data.pos_x;
         a_item_ff.pos_y <= req.data.pos_y;
         a_item_ff.pos_z <= req.data.pos_z;
         a_item_ff.d_x <= DiffWidth'(req.data.want_x) - DiffWidth'(req.data.vel_x);
         a_item_ff.d_y <= DiffWidth'(req.data.want_y) - DiffWidth'(req.data.vel_y);
         a_item_ff.d_z <= DiffWidth'(req.data.want_z) - DiffWidth'(req.data.vel_z);
         a_item_ff.lim <= LimWidth'(({31'd0, req.data.max_accel}
                                     * {31'd0, time_step_ff}) >> FracBits);
         a_item_ff.sum <= '0;
         a_item_ff.root <= '0;
         a_item_ff.limited <= 1'b0;
      end
   end

   // Stage B: squares of each component
   logic                b_valid_ff;
   item_type            b_item_ff;
   logic [65:0]         b_sq_ff [3];
   logic [DiffWidth-1:0] mag_d [3];
   always_comb begin
      mag_d[0] = a_item_ff.d_x[DiffWidth-1] ? -a_item_ff.d_x : a_item_ff.d_x;
      mag_d[1] = a_item_ff.d_y[DiffWidth-1] ? -a_item_ff.d_y : a_item_ff.d_y;
      mag_d[2] = a_item_ff.d_z[DiffWidth-1] ? -a_item_ff.d_z : a_item_ff.d_z;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         b_valid_ff <= a_valid_ff;
      end
      if (!ctl.stall) begin
         b_item_ff <= a_item_ff;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= {33'd0, mag_d[i]} * {33'd0, mag_d[i]};
         end
      end
   end

   // Stage C: sum of squares
   logic     c_valid_ff;
   item_type c_item_ff, c_item_in;
   logic [SumWidth-1:0] s_sum;
   always_comb begin
      s_sum = SumWidth'(b_sq_ff[0]) + SumWidth'(b_sq_ff[1]) + SumWidth'(b_sq_ff[2]);
      c_item_in     = b_item_ff;
      c_item_in.sum = s_sum;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         c_valid_ff <= b_valid_ff;
      end
      if (!ctl.stall) begin
         c_item_ff <= c_item_in;
      end
   end

   // Square-root chain
   logic     r_valid [NumCells+1];
   item_type r_item  [NumCells+1];
   assign r_valid[0] = c_valid_ff;
   assign r_item[0]  = c_item_ff;
   for (genvar g = 0; g < NumCells; g++) begin : g_root
      alvi_root_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .bit_pos(6'(NumCells - 1 - g)),
         .in_valid(r_valid[g]), .in_item(r_item[g]),
         .out_valid(r_valid[g+1]), .out_item(r_item[g+1])
      );
   end

   // Limit test: S > M^2 exactly when the root exceeds M, or equals M
   // with a nonzero remainder left over.
   item_type            r_out;
   logic [LimWidth-1:0] r_root;
   always_comb begin
      r_out  = r_item[NumCells];
      r_root = LimWidth'(r_item[NumCells].root);
      r_out.limited = (r_root > r_out.lim)
                   || (r_root == r_out.lim && r_out.sum != '0);
   end

   // Division chain: f = floor(M * 2^28 / ds). Leading quotient bits are
   // zero whenever the change is limited (M <= ds), so start from the
   // leading numerator bits as remainder.
   logic                 q_valid [QuoBits+1];
   item_type             q_item  [QuoBits+1];
   logic [RootWidth:0]   q_rem   [QuoBits+1];
   logic [FactWidth-1:0] q_quo   [QuoBits+1];
   logic [LimWidth+ScaleBits-1:0] num0;
   assign num0       = {r_item[NumCells].lim, {ScaleBits{1'b0}}};
   assign q_valid[0] = r_valid[NumCells];
   assign q_item[0]  = r_out;
   assign q_rem[0]   = (RootWidth+1)'(num0 >> QuoBits);
   assign q_quo[0]   = '0;
   for (genvar g = 0; g < QuoBits; g++) begin : g_div
      alvi_div_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .bit_pos(6'(QuoBits - 1 - g)),
         .in_valid(q_valid[g]), .in_item(q_item[g]),
         .in_rem(q_rem[g]), .in_quo(q_quo[g]),
         .out_valid(q_valid[g+1]), .out_item(q_item[g+1]),
         .out_rem(q_rem[g+1]), .out_quo(q_quo[g+1])
      );
   end

   // Stage D: scale the change (magnitudes times f) when it is limited
   item_type             dq;
   logic [FactWidth-1:0] fq;
   logic [DiffWidth-1:0] dmag [3];
   logic                 dneg [3];
   logic                 d_valid_ff;
   item_type             d_item_ff;
   logic [DiffWidth-1:0] d_mag_ff [3];
   logic                 d_neg_ff [3];
   logic [61:0]          prod_d [3];
   assign dq = q_item[QuoBits];
   assign fq = (dq.root == '0) ? '0 : q_quo[QuoBits];
   always_comb begin
      dneg[0] = dq.d_x[DiffWidth-1];
      dneg[1] = dq.d_y[DiffWidth-1];
      dneg[2] = dq.d_z[DiffWidth-1];
      dmag[0] = dneg[0] ? -dq.d_x : dq.d_x;
      dmag[1] = dneg[1] ? -dq.d_y : dq.d_y;
      dmag[2] = dneg[2] ? -dq.d_z : dq.d_z;
      for (int i = 0; i < 3; i++) begin
         prod_d[i] = {29'd0, dmag[i]} * {33'd0, fq};
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         d_valid_ff <= q_valid[QuoBits];
      end
      if (!ctl.stall) begin
         d_item_ff <= dq;
         for (int i = 0; i < 3; i++) begin
            d_neg_ff[i] <= dneg[i];
            d_mag_ff[i] <= dq.limited ? DiffWidth'(prod_d[i] >> ScaleBits) : dmag[i];
         end
      end
   end

   // Stage E: new velocity
   logic                  e_valid_ff;
   item_type              e_item_ff;
   logic [WordWidth-1:0]  e_nv_ff [3];
   logic signed [WordWidth+1:0] nv_sum [3];
   logic signed [WordWidth+1:0] dsig [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dsig[i] = d_neg_ff[i] ? -$signed({1'b0, d_mag_ff[i]}) : $signed({1'b0, d_mag_ff[i]});
      end
      nv_sum[0] = (WordWidth+2)'(d_item_ff.vel_x) + dsig[0];
      nv_sum[1] = (WordWidth+2)'(d_item_ff.vel_y) + dsig[1];
      nv_sum[2] = (WordWidth+2)'(d_item_ff.vel_z) + dsig[2];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         e_valid_ff <= d_valid_ff;
      end
      if (!ctl.stall) begin
         e_item_ff <= d_item_ff;
         for (int i = 0; i < 3; i++) begin
            e_nv_ff[i] <= sat32(nv_sum[i]);
         end
      end
   end

   // Stage F: speed squares and position step products
   logic                 f_valid_ff;
   item_type             f_item_ff;
   logic [WordWidth-1:0] f_nv_ff [3];
   logic [63:0]          f_sq_ff [3];
   logic [62:0]          f_step_ff [3];
   logic [WordWidth-1:0] vmag [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vmag[i] = e_nv_ff[i][WordWidth-1] ? -e_nv_ff[i] : e_nv_ff[i];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         f_valid_ff <= e_valid_ff;
      end
      if (!ctl.stall) begin
         f_item_ff <= e_item_ff;
         for (int i = 0; i < 3; i++) begin
            f_nv_ff[i]   <= e_nv_ff[i];
            f_sq_ff[i]   <= {32'd0, vmag[i]} * {32'd0, vmag[i]};
            f_step_ff[i] <= {31'd0, vmag[i]} * {32'd0, time_step_ff};
         end
      end
   end

   // Stage G: rest test, position update, output register
   logic       g_valid_ff;
   rsp_type    g_data_ff, g_data_in;
   logic [65:0] speed_sq;
   logic [61:0] rest_sq;
   logic        rest;
   logic [WordWidth-1:0] np [3];
   logic [WordWidth:0]   step_mag [3];
   logic signed [WordWidth+1:0] step_s [3];
   logic [WordWidth-1:0] pos [3];
   always_comb begin
      speed_sq = 66'(f_sq_ff[0]) + 66'(f_sq_ff[1]) + 66'(f_sq_ff[2]);
      rest_sq  = {31'd0, rest_speed_ff} * {31'd0, rest_speed_ff};
      rest     = !(speed_sq > {4'd0, rest_sq});
      pos[0] = f_item_ff.pos_x;
      pos[1] = f_item_ff.pos_y;
      pos[2] = f_item_ff.pos_z;
      for (int i = 0; i < 3; i++) begin
         // a step of 2^32 or more saturates anyway: clamp it there
         step_mag[i] = (f_step_ff[i][62:FracBits+WordWidth] != '0)
                     ? {1'b1, {WordWidth{1'b0}}}
                     : {1'b0, f_step_ff[i][FracBits+WordWidth-1:FracBits]};
         step_s[i] = f_nv_ff[i][WordWidth-1]
                   ? -$signed({1'b0, step_mag[i]})
                   :  $signed({1'b0, step_mag[i]});
         np[i] = rest ? pos[i]
                      : sat32($signed({{2{pos[i][WordWidth-1]}}, pos[i]}) + step_s[i]);
      end
      g_data_in.new_vel_x   = rest ? '0 : f_nv_ff[0];
      g_data_in.new_vel_y   = rest ? '0 : f_nv_ff[1];
      g_data_in.new_vel_z   = rest ? '0 : f_nv_ff[2];
      g_data_in.new_pos_x   = np[0];
      g_data_in.new_pos_y   = np[1];
      g_data_in.new_pos_z   = np[2];
      g_data_in.was_limited = f_item_ff.limited;
      g_data_in.at_rest     = rest;
   end

   // Stall the whole chain only when the output register holds an untaken result
   assign ctl.valid = g_valid_ff;
   assign ctl.stall = g_valid_ff && !rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (!ctl.stall) begin
         g_valid_ff <= f_valid_ff;
      end
      if (!ctl.stall) begin
         g_data_ff <= g_data_in;
      end
   end

   assign req.ready = !ctl.stall;
   assign rsp.valid = ctl.valid;
   assign rsp.data  = g_data_ff;
endmodule

[rtl/core/alvi_checker.sv]
module alvi_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input alvi_pkg::rsp_type    rsp_data
);
   import alvi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped while stalled");

   a_rest_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.at_rest |-> rsp_data.new_vel_x == '0
         && rsp_data.new_vel_y == '0 && rsp_data.new_vel_z == '0)
      else $error("at rest with nonzero velocity");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == !(rsp_valid && !rsp_ready))
      else $error("ready not tied to output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind accel_limited_velocity_integrator alvi_checker u_alvi_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
